### rtl/sstf_pkg.sv
// shared types and constants for the shortest-seek-first disk scheduler
// no dependencies; imported by the scheduler top level
package sstf_pkg;

   // field widths of the request and response transactions
   localparam int TrackWidth = 16;
   localparam int SeekWidth  = 22;
   localparam int RspDataWidth = 56;

   // sequencer states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_PICK
   } state_type;

endpackage

### rtl/sstf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; used for the request store of the scheduler
module sstf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sstf_disk_scheduler.sv
// shortest-seek-time-first disk scheduler, top level
// depends on sstf_pkg and sstf_ram
//
// Requests are loaded one per transaction into a store of DEPTH entries; requests beyond
// DEPTH are dropped and flagged as overflow in every response of the batch.
// The request with tlast set starts service from csr start_head: the block then emits one
// response per stored request, nearest unserved track first, earliest loaded on a tie.
// Each pick rescans every stored request (plus any wait on rsp_tready), because one
// distance comparator walks the store through a single registered ram read port.
// req_tready is low during service.
// start_head may be written only while the block is idle.
module sstf_disk_scheduler #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] track
   input  logic        req_tlast,   // last request of the batch
   // response transaction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [sstf_pkg::RspDataWidth-1:0] rsp_tdata, // [15:0] served_track,
                                                        // [31:16] move_distance,
                                                        // [53:32] total_seek
   output logic        rsp_tuser,   // [0] overflow
   output logic        rsp_tlast,   // last served request of the batch
   // start head register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // [15:0] start_head
);

   import sstf_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic [TrackWidth-1:0] head_ff, head_in;
   logic [SeekWidth-1:0]  seek_ff, seek_in;
   logic [DEPTH-1:0]      served_ff, served_in;
   logic [CW-1:0]         picks_ff, picks_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic                  cmp_last_ff, cmp_last_in;
   logic [AW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   logic [TrackWidth-1:0] best_dist_ff, best_dist_in;
   logic [TrackWidth-1:0] best_track_ff, best_track_in;
   logic [TrackWidth-1:0] start_head_ff, start_head_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  wr_en;
   logic [AW-1:0]         rd_addr;
   logic [TrackWidth-1:0] rd_data;
   logic [TrackWidth:0]   diff;
   logic [TrackWidth-1:0] cand_dist;
   logic                  req_accept;
   logic                  pick_last;
   logic [SeekWidth-1:0]  seek_next;

   // request store
   sstf_ram #(
      .WIDTH (TrackWidth),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared distance unit: |stored track - head|
   assign diff = {1'b0, rd_data} - {1'b0, head_ff};
   assign cand_dist = diff[TrackWidth] ? TrackWidth'(~diff[TrackWidth-1:0] + 1'b1)
                                       : diff[TrackWidth-1:0];

   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign wr_en      = req_accept && (count_ff < CW'(DEPTH));
   assign rd_addr    = addr_ff[AW-1:0];
   assign pick_last  = (picks_ff + CW'(1)) == count_ff;
   assign seek_next  = seek_ff + SeekWidth'(best_dist_ff);

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         head_ff       <= '0;
         seek_ff       <= '0;
         served_ff     <= '0;
         picks_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         start_head_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         head_ff       <= head_in;
         seek_ff       <= seek_in;
         served_ff     <= served_in;
         picks_ff      <= picks_in;
         cmp_valid_ff  <= cmp_valid_in;
         start_head_ff <= start_head_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      cmp_last_ff   <= cmp_last_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_dist_ff  <= best_dist_in;
      best_track_ff <= best_track_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // sequencer: load, scan the store, emit the pick
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      head_in       = head_ff;
      seek_in       = seek_ff;
      served_in     = served_ff;
      picks_in      = picks_ff;
      addr_in       = addr_ff;
      cmp_valid_in  = 1'b0;
      cmp_last_in   = cmp_last_ff;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      best_track_in = best_track_ff;
      start_head_in = start_head_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;

      // start head register write
      if (csr_valid) begin
         start_head_in = csr_data;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (count_ff < CW'(DEPTH)) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in  = ST_SCAN;
                  head_in   = start_head_ff;
                  seek_in   = '0;
                  served_in = '0;
                  picks_in  = '0;
                  addr_in   = '0;
                  found_in  = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // issue one store read per cycle
            if (addr_ff < count_ff) begin
               addr_in      = addr_ff + CW'(1);
               cmp_valid_in = 1'b1;
               cmp_last_in  = (addr_ff + CW'(1)) == count_ff;
               cmp_idx_in   = addr_ff[AW-1:0];
            end
            // compare returned entry against best so far
            if (cmp_valid_ff) begin
               if (!served_ff[cmp_idx_ff] && (!found_ff || cand_dist < best_dist_ff)) begin
                  found_in      = 1'b1;
                  best_idx_in   = cmp_idx_ff;
                  best_dist_in  = cand_dist;
                  best_track_in = rd_data;
               end
               if (cmp_last_ff) begin
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            // hand the pick to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, seek_next, best_dist_ff, best_track_ff};
               rsp_user_in  = overflow_ff;
               rsp_last_in  = pick_last;
               served_in[best_idx_ff] = 1'b1;
               head_in      = best_track_ff;
               seek_in      = seek_next;
               picks_in     = picks_ff + CW'(1);
               addr_in      = '0;
               found_in     = 1'b0;
               if (pick_last) begin
                  state_in    = ST_LOAD;
                  count_in    = '0;
                  overflow_in = 1'b0;
                  served_in   = '0;
                  picks_in    = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // a new response only appears right after a pick
   a_rsp_from_pick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_PICK))
      else $error("response raised outside pick");

   // the store fill never passes its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("request count beyond depth");

   // while scanning, some stored request is still unserved
   a_picks_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (picks_ff < count_ff))
      else $error("scan with every request served");
`endif

endmodule
